[src/wpq_pkg.sv]
package wpq_pkg;

    localparam int GRADE_W   = 14;
    localparam int COURSES_W = 8;
    localparam int PRIO_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int FIELD_ID_W = 16;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic CFG_GRADE_SCALE  = 1'b0;
    localparam logic CFG_COURSE_TOTAL = 1'b1;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [FIELD_ID_W-1:0]  item_id;
        logic [GRADE_W-1:0]     grade;
        logic [COURSES_W-1:0]   courses;
    } t_req;

    typedef struct packed {
        logic                   status;
        logic                   is_empty;
        logic [COUNT_W-1:0]     count;
        logic [FIELD_ID_W-1:0]  head_id;
        logic [GRADE_W-1:0]     head_grade;
        logic [COURSES_W-1:0]   head_courses;
        logic [PRIO_W-1:0]      head_priority;
    } t_rsp;

    // Control broadcast to every cell of the sorted row.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

[src/wpq_div.sv]
// Restoring divider, one quotient bit per cycle.
module wpq_div import wpq_pkg::*; #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_shift;
    logic [DEN_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (!n_diff[DEN_W]) begin
                    r_rem <= n_diff;
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[src/wpq_cell.sv]
// One slot of the sorted row. On push, a cell keeps its entry, takes the new
// one, or takes its upper neighbor's entry; on pop it takes its lower neighbor's.
module wpq_cell import wpq_pkg::*; #(
    parameter int ID_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [PRIO_W-1:0]    i_new_prio,
    input  logic [ID_W-1:0]      i_new_id,
    input  logic [GRADE_W-1:0]   i_new_grade,
    input  logic [COURSES_W-1:0] i_new_courses,
    input  logic                 i_up_valid,
    input  logic                 i_up_goes,
    input  logic [PRIO_W-1:0]    i_up_prio,
    input  logic [ID_W-1:0]      i_up_id,
    input  logic [GRADE_W-1:0]   i_up_grade,
    input  logic [COURSES_W-1:0] i_up_courses,
    input  logic                 i_dn_valid,
    input  logic [PRIO_W-1:0]    i_dn_prio,
    input  logic [ID_W-1:0]      i_dn_id,
    input  logic [GRADE_W-1:0]   i_dn_grade,
    input  logic [COURSES_W-1:0] i_dn_courses,
    output logic                 o_valid,
    output logic                 o_goes,
    output logic [PRIO_W-1:0]    o_prio,
    output logic [ID_W-1:0]      o_id,
    output logic [GRADE_W-1:0]   o_grade,
    output logic [COURSES_W-1:0] o_courses
);
    logic                 r_valid;
    logic [PRIO_W-1:0]    r_prio;
    logic [ID_W-1:0]      r_id;
    logic [GRADE_W-1:0]   r_grade;
    logic [COURSES_W-1:0] r_courses;
    logic                 n_goes;

    // The new entry lands ahead of this one unless this one is strictly higher.
    assign n_goes = !r_valid || (r_prio <= i_new_prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            // The first empty slot fills; the head slot sees a valid upper side.
            r_valid <= r_valid || i_up_valid;
            if (n_goes && i_up_goes && i_up_valid) begin
                r_prio <= i_up_prio; r_id <= i_up_id;
                r_grade <= i_up_grade; r_courses <= i_up_courses;
            end else if (n_goes) begin
                r_prio <= i_new_prio; r_id <= i_new_id;
                r_grade <= i_new_grade; r_courses <= i_new_courses;
            end
        end else if (i_ctl.pop) begin
            r_valid <= i_dn_valid;
            r_prio <= i_dn_prio; r_id <= i_dn_id;
            r_grade <= i_dn_grade; r_courses <= i_dn_courses;
        end
    end

    assign o_valid   = r_valid;
    assign o_goes    = n_goes;
    assign o_prio    = r_prio;
    assign o_id      = r_id;
    assign o_grade   = r_grade;
    assign o_courses = r_courses;
endmodule

[src/weighted_priority_queue_top.sv]
// Sorted priority queue of DEPTH entries, highest priority at the head.
// Push computes priority = floor(65536*(0.3*grade/grade_scale +
// 0.7*courses/course_total)) saturated at 65535, by a bit-serial divider
// of 56 quotient bits; a push waits for that divider, pop and query do
// not. Entries sit in a row of cells that shift together to open or
// close a slot; equal priorities go behind nothing, i.e.
// a new entry is placed ahead of all equal ones. A push to a full queue
// is dropped with status 1. One request is in flight at a time.
module weighted_priority_queue_top import wpq_pkg::*; #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NUM_W = 56;
    localparam int DEN_W = 26;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_APPLY} t_state;

    t_state               r_state;
    logic [GRADE_W-1:0]   r_grade_scale;
    logic [COURSES_W-1:0] r_total;
    logic [CNT_W-1:0]     r_held;
    t_req                 r_req;
    logic                 r_out_valid;
    logic                 r_status;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [PRIO_W-1:0]    r_prio;
    logic                 r_push_en;
    logic                 r_pop_en;
    logic                 r_div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;
    logic [GRADE_W-1:0]   m_eff;
    logic [COURSES_W-1:0] t_eff;
    logic                 accept;
    t_cell_ctl            ctl;

    logic                 c_valid   [DEPTH];
    logic                 c_goes    [DEPTH];
    logic [PRIO_W-1:0]    c_prio    [DEPTH];
    logic [ID_BITS-1:0]   c_id      [DEPTH];
    logic [GRADE_W-1:0]   c_grade   [DEPTH];
    logic [COURSES_W-1:0] c_courses [DEPTH];

    assign m_eff  = (r_grade_scale == '0) ? GRADE_W'(1) : r_grade_scale;
    assign t_eff  = (r_total == '0) ? COURSES_W'(1) : r_total;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign ctl.push = r_push_en;
    assign ctl.pop  = r_pop_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grade_scale <= GRADE_W'(1000);
            r_total       <= COURSES_W'(40);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRADE_SCALE:  r_grade_scale <= i_cfg_data;
                CFG_COURSE_TOTAL: r_total       <= i_cfg_data[COURSES_W-1:0];
                default: ;
            endcase
        end
    end

    wpq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_push_en   <= 1'b0;
            r_pop_en    <= 1'b0;
            r_div_start <= 1'b0;
            r_status    <= 1'b0;
        end else begin
            r_push_en   <= 1'b0;
            r_pop_en    <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req;
                        r_status <= 1'b0;
                        if (i_req.cmd == CMD_PUSH) begin
                            if (r_held >= CNT_W'(DEPTH)) begin
                                r_status <= 1'b1;
                                r_state  <= S_APPLY;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end else if (i_req.cmd == CMD_POP && r_held != '0) begin
                            r_pop_en <= 1'b1;
                            r_held   <= r_held - 1'b1;
                            r_state  <= S_APPLY;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_MUL: begin
                    // Hold products for the divider.
                    r_num <= NUM_W'({(30'(3 * r_req.grade) * 30'(t_eff)) +
                                     (30'(7 * r_req.courses) * 30'(m_eff)), 16'd0});
                    r_den <= DEN_W'(10 * m_eff) * DEN_W'(t_eff);
                    r_div_start <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_prio <= (div_quot > NUM_W'(65535)) ? PRIO_W'(65535)
                                                             : div_quot[PRIO_W-1:0];
                        r_push_en <= 1'b1;
                        r_held    <= r_held + 1'b1;
                        r_state   <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int UP = (g == 0) ? 0 : g - 1;
        localparam int DN = (g == DEPTH - 1) ? g : g + 1;
        wpq_cell #(.ID_W(ID_BITS)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_prio    (r_prio),
            .i_new_id      (ID_BITS'(r_req.item_id)),
            .i_new_grade   (r_req.grade),
            .i_new_courses (r_req.courses),
            .i_up_valid    ((g == 0) ? 1'b1 : c_valid[UP]),
            .i_up_goes     ((g == 0) ? 1'b0 : c_goes[UP]),
            .i_up_prio     (c_prio[UP]),
            .i_up_id       (c_id[UP]),
            .i_up_grade    (c_grade[UP]),
            .i_up_courses  (c_courses[UP]),
            .i_dn_valid    ((g == DEPTH - 1) ? 1'b0 : c_valid[DN]),
            .i_dn_prio     (c_prio[DN]),
            .i_dn_id       (c_id[DN]),
            .i_dn_grade    (c_grade[DN]),
            .i_dn_courses  (c_courses[DN]),
            .o_valid       (c_valid[g]),
            .o_goes        (c_goes[g]),
            .o_prio        (c_prio[g]),
            .o_id          (c_id[g]),
            .o_grade       (c_grade[g]),
            .o_courses     (c_courses[g])
        );
    end

    always_comb begin
        o_valid              = r_out_valid;
        o_rsp.status         = r_status;
        o_rsp.is_empty       = (r_held == '0);
        o_rsp.count          = COUNT_W'(r_held);
        o_rsp.head_id        = c_valid[0] ? FIELD_ID_W'(c_id[0]) : '0;
        o_rsp.head_grade     = c_valid[0] ? c_grade[0] : '0;
        o_rsp.head_courses   = c_valid[0] ? c_courses[0] : '0;
        o_rsp.head_priority  = c_valid[0] ? c_prio[0] : '0;
    end
endmodule

[tb/wpq_checker.sv]
module wpq_checker import wpq_pkg::*; #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_up,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  t_rsp        i_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_drops,
    output int          o_pushes
);

    typedef struct {
        logic [FIELD_ID_W-1:0] id;
        logic [GRADE_W-1:0]    grade;
        logic [COURSES_W-1:0]  courses;
        logic [PRIO_W-1:0]     prio;
    } t_entry;

    t_entry           queue_rows[$];
    t_rsp             expected_rsps[$];
    logic [13:0]      grade_scale_reg;
    logic [7:0]       course_total_reg;

    function automatic logic [PRIO_W-1:0] weighted_prio(logic [13:0] g, logic [7:0] c);
        longint unsigned m;
        longint unsigned t;
        longint unsigned num;
        longint unsigned q;
        m = (grade_scale_reg == 0) ? 1 : grade_scale_reg;
        t = (course_total_reg == 0) ? 1 : course_total_reg;
        num = 65536 * (3 * longint'(g) * t + 7 * longint'(c) * m);
        q = num / (10 * m * t);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    task automatic apply_request(t_req r);
        t_rsp   e;
        t_entry n;
        int     pos;
        e = '0;
        if (r.cmd == CMD_PUSH) begin
            o_pushes++;
            if (queue_rows.size() >= DEPTH) begin
                e.status = 1'b1;
                o_drops++;
            end else begin
                n.id = r.item_id & FIELD_ID_W'((64'd1 << ID_BITS) - 64'd1);
                n.grade = r.grade;
                n.courses = r.courses;
                n.prio = weighted_prio(r.grade, r.courses);
                pos = 0;
                while (pos < queue_rows.size() && queue_rows[pos].prio > n.prio)
                    pos++;
                queue_rows.insert(pos, n);
            end
        end else if (r.cmd == CMD_POP) begin
            if (queue_rows.size() > 0)
                void'(queue_rows.pop_front());
        end
        e.is_empty = (queue_rows.size() == 0);
        e.count = COUNT_W'(queue_rows.size());
        if (queue_rows.size() > 0) begin
            e.head_id = queue_rows[0].id;
            e.head_grade = queue_rows[0].grade;
            e.head_courses = queue_rows[0].courses;
            e.head_priority = queue_rows[0].prio;
        end
        expected_rsps.push_back(e);
    endtask

    task automatic compare_rsp(t_rsp got);
        t_rsp e;
        if (expected_rsps.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
        end
        e = expected_rsps.pop_front();
        if (got.status !== e.status) report("status", got.status, e.status);
        if (got.is_empty !== e.is_empty) report("is_empty", got.is_empty, e.is_empty);
        if (got.count !== e.count) report("count", got.count, e.count);
        if (got.head_id !== e.head_id) report("head_id", got.head_id, e.head_id);
        if (got.head_grade !== e.head_grade)
            report("head_grade", got.head_grade, e.head_grade);
        if (got.head_courses !== e.head_courses)
            report("head_courses", got.head_courses, e.head_courses);
        if (got.head_priority !== e.head_priority)
            report("head_priority", got.head_priority, e.head_priority);
    endtask

    initial begin
        o_errors = 0;
        o_drops = 0;
        o_pushes = 0;
        grade_scale_reg = 14'd1000;
        course_total_reg = 8'd40;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queue_rows.delete();
            expected_rsps.delete();
            grade_scale_reg = 14'd1000;
            course_total_reg = 8'd40;
        end else begin
            // responses first: a request accepted in this edge cannot answer in it
            if (i_rsp_valid && !i_rsp_stall)
                compare_rsp(i_rsp);
            if (i_valid && !i_stall_up)
                apply_request(i_req);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRADE_SCALE)
                    grade_scale_reg = i_cfg_data;
                else
                    course_total_reg = i_cfg_data[7:0];
            end
        end
        o_pending = expected_rsps.size();
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import wpq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_req        i_req;
    logic        o_valid;
    logic        i_stall;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [13:0] i_cfg_data;
    int          errors;
    int          pending;
    int          drops;
    int          pushes;
    int          cycle_count;
    bit          idle_ok;
    int          requests_sent;

    weighted_priority_queue_top #(.DEPTH(DEPTH), .ID_BITS(16)) uut (.*);

    wpq_checker #(.DEPTH(DEPTH), .ID_BITS(16)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_up  (o_stall),
        .i_req       (i_req),
        .i_rsp_valid (o_valid),
        .i_rsp_stall (i_stall),
        .i_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_drops     (drops),
        .o_pushes    (pushes)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Random stall on the response side, quiet while idle_ok is clear.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= idle_ok && ($urandom_range(99) < 30);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Leaves valid high on return; the next idle gap or caller drops it.
    task automatic send_request(logic [1:0] cmd, logic [15:0] id, logic [13:0] g,
                                logic [7:0] c);
        t_req r;
        while (idle_ok && ($urandom_range(99) < 30)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        r.cmd = cmd;
        r.item_id = id;
        r.grade = g;
        r.courses = c;
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    task automatic write_reg(logic idx, logic [13:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int          pick;
        logic [1:0]  cmd;
        logic [13:0] g;
        logic [7:0]  c;
        pick = $urandom_range(99);
        cmd = (pick < 50) ? CMD_PUSH : (pick < 85) ? CMD_POP : 2'($urandom_range(3, 2));
        g = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(10000));
        c = 8'($urandom);
        send_request(cmd, 16'($urandom), g, c);
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GRADE_SCALE;
        i_cfg_data = '0;
        idle_ok = 1'b0;
        cycle_count = 0;
        requests_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, extremes, ties, fill past full, unused code
        send_request(CMD_POP, 16'h0, 14'h0, 8'h0);
        send_request(CMD_QUERY, 16'hFFFF, 14'h3FFF, 8'hFF);
        send_request(CMD_RSVD, 16'h0, 14'h0, 8'h0);
        send_request(CMD_PUSH, 16'h0000, 14'd0, 8'd0);
        send_request(CMD_PUSH, 16'hFFFF, 14'h3FFF, 8'hFF);
        send_request(CMD_PUSH, 16'h1234, 14'd1000, 8'd40);
        send_request(CMD_PUSH, 16'h5678, 14'd500, 8'd20);
        send_request(CMD_PUSH, 16'h9ABC, 14'd500, 8'd20);
        for (k = 0; k < 14; k++)
            send_request(CMD_PUSH, 16'(k * 4099), 14'(k * 700), 8'(k * 17));
        for (k = 0; k < 3; k++)
            send_request(CMD_POP, 16'h0, 14'h0, 8'h0);

        // register settings, extremes included, zero divisor too
        write_reg(CFG_GRADE_SCALE, 14'd1);
        write_reg(CFG_COURSE_TOTAL, 14'd255);
        idle_ok = 1'b1;
        for (k = 0; k < 450; k++) begin
            case (k)
                90: begin
                    write_reg(CFG_GRADE_SCALE, 14'd10000);
                    write_reg(CFG_COURSE_TOTAL, 14'd1);
                end
                180: begin
                    write_reg(CFG_GRADE_SCALE, 14'h3FFF);
                    write_reg(CFG_COURSE_TOTAL, 14'h0);
                end
                270: begin
                    idle_ok = 1'b0;
                    write_reg(CFG_GRADE_SCALE, 14'd0);
                    write_reg(CFG_COURSE_TOTAL, 14'h3FC0 | 14'd40);
                end
                360: begin
                    idle_ok = 1'b1;
                    write_reg(CFG_GRADE_SCALE, 14'($urandom_range(10000, 1)));
                    write_reg(CFG_COURSE_TOTAL, 14'($urandom_range(255, 1)));
                end
                default: ;
            endcase
            random_request();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        $display("sent %0d requests, %0d pushes of which %0d dropped full",
                 requests_sent, pushes, drops);
        $display("register settings spanned divisors from zero to full scale");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[weighted_priority_queue_top.f]
src/wpq_pkg.sv
src/wpq_div.sv
src/wpq_cell.sv
src/weighted_priority_queue_top.sv
tb/wpq_checker.sv
tb/tb_top.sv
